// ----- src/drht_pkg.sv -----
// Shared types, widths and command codes for the change-history tracker.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package drht_pkg;

  localparam int HistDepth = 16;
  localparam int IndexBits = 32;
  localparam int StampBits = 32;
  localparam int AddrBits  = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int FillBits  = $clog2(HistDepth + 1);

  typedef logic [IndexBits-1:0] index_t;
  typedef logic [IndexBits:0]   span_end_t;
  typedef logic [StampBits-1:0] stamp_t;
  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [FillBits-1:0]  fill_t;

  typedef enum logic [1:0] {
    CMD_MARK   = 2'd0,
    CMD_RESIZE = 2'd1,
    CMD_TOUCH  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_LOCKED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    stamp_t stamp;
    index_t first;
    index_t count;
    logic   whole;
  } entry_t;

  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } ring_ctl_t;

  typedef struct packed {
    logic clear;
    logic load;
  } merge_ctl_t;

  function automatic addr_t ring_slot(addr_t head, fill_t offset);
    logic [FillBits:0] sum;
    sum = (FillBits + 1)'(head) + (FillBits + 1)'(offset);
    if (sum >= (FillBits + 1)'(HistDepth)) begin
      sum = sum - (FillBits + 1)'(HistDepth);
    end
    return sum[AddrBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/drht_ring.sv -----
// History ring storage: one write port and one registered read port.
// Depends on drht_pkg for the entry layout and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module drht_ring (
  input  wire                  clk,
  input  drht_pkg::ring_ctl_t  ctl,
  output drht_pkg::entry_t     rd_data
);
  import drht_pkg::*;

  entry_t mem [HistDepth];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/drht_merge.sv -----
// Shared span union unit: folds one history range per cycle into a lowest
// first index and a highest end. Depends on drht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drht_merge (
  input  wire                    clk,
  input  wire                    rst,
  input  drht_pkg::merge_ctl_t   ctl,
  input  drht_pkg::index_t       first,
  input  drht_pkg::index_t       count,
  output logic                   found,
  output drht_pkg::index_t       lo,
  output drht_pkg::span_end_t    hi
);
  import drht_pkg::*;

  span_end_t end_v;

  assign end_v = {1'b0, first} + {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.load) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!found || first < lo) begin
        lo <= first;
      end
      if (!found || end_v > hi) begin
        hi <= end_v;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/dirty_range_history_tracker.sv -----
// Top level of the change-history tracker: command decode, stamp and ring
// bookkeeping, the query sequencer and the result register.
// Depends on drht_pkg, drht_ring and drht_merge.
`timescale 1ns / 1ps
`default_nettype none

// Mark, resize and touch requests finish in the cycle they are accepted, and so
// does a query that is current or that must report the whole array before any
// history is read. Any other query walks the filled part of the history ring
// from oldest to newest, one entry per cycle through the single ring read port
// and the shared union unit; it stops early at a newer whole-array entry or
// when a full ring of 16 does not reach back to the asked stamp. Its result
// is registered from the S_FIN state. The block takes no new request while a
// query is walking or while a result waits to be taken.
module dirty_range_history_tracker (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire                       cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [1:0]                cmd,
  input  wire  drht_pkg::index_t    first_index,
  input  wire  drht_pkg::index_t    range_count,
  input  wire  drht_pkg::index_t    element_total,
  input  wire  drht_pkg::stamp_t    since_stamp,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [1:0]                status,
  output drht_pkg::index_t          out_first,
  output drht_pkg::index_t          out_count,
  output logic                      out_whole,
  output drht_pkg::stamp_t          stamp_now
);
  import drht_pkg::*;

  state_t     state;
  state_t     state_next;
  cmd_t       cmd_op;
  logic       accept;
  logic       writable;
  stamp_t     stamp;
  addr_t      head;
  fill_t      fill;
  logic       newest_cur;
  fill_t      issue_k;
  logic       issue_more;
  logic       rd_valid;
  logic       rd_oldest;
  logic       rd_last;
  stamp_t     since_q;
  index_t     total_q;
  logic       whole_q;
  ring_ctl_t  ring_ctl;
  entry_t     rd_data;
  merge_ctl_t merge_ctl;
  logic       m_found;
  index_t     m_lo;
  span_end_t  m_hi;
  logic       range_bad;
  logic       do_push;
  logic       q_current;
  logic       q_early_whole;
  logic       start_scan;
  logic       hit;
  logic       stale;
  logic       abort;
  logic       finish;
  status_t    rec_status;

  assign cfg_ready = 1'b1;
  assign cmd_op    = cmd_t'(cmd);
  assign accept    = in_valid && in_ready;
  assign stamp_now = stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      writable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      writable <= cfg_data;
    end
  end

  always_comb begin
    range_bad     = (first_index > element_total) ||
                    (range_count > (element_total - first_index));
    q_current     = since_stamp >= stamp;
    q_early_whole = (since_stamp == '0) || (fill == '0) || !newest_cur;
    do_push       = 1'b0;
    rec_status    = STATUS_OK;
    unique case (cmd_op)
      CMD_MARK: begin
        if (range_bad) begin
          rec_status = STATUS_RANGE;
        end else if (!writable && range_count != '0) begin
          rec_status = STATUS_LOCKED;
        end else begin
          do_push = range_count != '0;
        end
      end
      CMD_RESIZE: do_push = range_count != element_total;
      CMD_TOUCH:  do_push = 1'b0;
      CMD_QUERY:  do_push = 1'b0;
      default:    do_push = 1'b0;
    endcase
    start_scan = accept && cmd_op == CMD_QUERY && !q_current && !q_early_whole;
  end

  assign issue_more = issue_k < fill;
  assign hit        = rd_valid && rd_data.stamp > since_q;
  assign stale      = rd_valid && rd_oldest && fill == fill_t'(HistDepth) &&
                      since_q < rd_data.stamp;
  assign abort      = stale || (hit && rd_data.whole);
  assign finish     = abort || (rd_valid && rd_last);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_FIN;
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready                 = (state == S_IDLE) && (!out_valid || out_ready);
    ring_ctl.wr_en           = accept && do_push;
    ring_ctl.wr_addr         = (fill < fill_t'(HistDepth)) ? ring_slot(head, fill) : head;
    ring_ctl.wr_data.stamp   = stamp + 1'b1;
    ring_ctl.wr_data.first   = (cmd_op == CMD_RESIZE) ? '0 : first_index;
    ring_ctl.wr_data.count   = range_count;
    ring_ctl.wr_data.whole   = cmd_op == CMD_RESIZE;
    ring_ctl.rd_en           = (state == S_SCAN) && issue_more;
    ring_ctl.rd_addr         = ring_slot(head, issue_k);
    merge_ctl.clear          = start_scan;
    merge_ctl.load           = (state == S_SCAN) && hit && !abort;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stamp      <= '0;
      head       <= '0;
      fill       <= '0;
      newest_cur <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= ring_ctl.rd_en;
      if (accept && do_push) begin
        stamp      <= stamp + 1'b1;
        newest_cur <= 1'b1;
        if (fill < fill_t'(HistDepth)) begin
          fill <= fill + 1'b1;
        end else begin
          head <= ring_slot(head, fill_t'(1));
        end
      end else if (accept && cmd_op == CMD_TOUCH) begin
        stamp      <= stamp + 1'b1;
        newest_cur <= 1'b0;
      end
      if ((accept && !start_scan) || state == S_FIN) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      issue_k <= '0;
      since_q <= since_stamp;
      total_q <= element_total;
      whole_q <= 1'b0;
    end else if (state == S_SCAN) begin
      if (issue_more) begin
        issue_k <= issue_k + 1'b1;
      end
      if (abort) begin
        whole_q <= 1'b1;
      end
    end
    rd_oldest <= issue_k == '0;
    rd_last   <= issue_k == fill_t'(fill - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (accept && !start_scan) begin
      out_first <= '0;
      out_count <= '0;
      out_whole <= 1'b0;
      status    <= (cmd_op == CMD_MARK) ? rec_status : STATUS_OK;
      if (cmd_op == CMD_QUERY && !q_current) begin
        out_count <= element_total;
        out_whole <= 1'b1;
      end
    end else if (state == S_FIN) begin
      status <= STATUS_OK;
      if (whole_q || !m_found) begin
        out_first <= '0;
        out_count <= total_q;
        out_whole <= 1'b1;
      end else begin
        out_first <= m_lo;
        out_count <= index_t'(m_hi - {1'b0, m_lo});
        out_whole <= 1'b0;
      end
    end
  end

  drht_ring u_ring (
    .clk     (clk),
    .ctl     (ring_ctl),
    .rd_data (rd_data)
  );

  drht_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (merge_ctl),
    .first (rd_data.first),
    .count (rd_data.count),
    .found (m_found),
    .lo    (m_lo),
    .hi    (m_hi)
  );

endmodule

`default_nettype wire
